@@ rtl/bafmt_pkg.sv @@
package bafmt_pkg;

  // Widths of the payload fields.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned CHAR_W  = 7;

  // Longest text that one byte can give, e.g. "-128".
  localparam int unsigned TEXT_MAX = 4;
  localparam int unsigned LEN_W    = 3;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [3:0]         digit_t;

  // Format selector codes.
  typedef enum logic [CMD_W-1:0] {
    FMT_OCT  = 3'd0,
    FMT_UDEC = 3'd1,
    FMT_HEX  = 3'd2,
    FMT_TDEC = 3'd3,
    FMT_SDEC = 3'd4
  } fmt_e;

  localparam char_t CH_PLUS  = 7'h2B;
  localparam char_t CH_MINUS = 7'h2D;
  localparam char_t CH_ZERO  = 7'h30;
  localparam char_t CH_UPPER_A = 7'h41;

  // Formatted text of one byte: entry 0 is the first character sent.
  typedef struct packed {
    logic [TEXT_MAX-1:0][CHAR_W-1:0] chars;
    len_t                            len;
  } text_t;

  // Maps a digit of up to base sixteen onto its ASCII character.
  function automatic char_t digit_char(input digit_t d);
    char_t c;
    if (d < 4'd10) begin
      c = CH_ZERO + char_t'(d);
    end else begin
      c = CH_UPPER_A + char_t'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

@@ rtl/bafmt_if.sv @@
interface bafmt_in_if import bafmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bafmt_out_if import bafmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   char_code;
  logic                last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ rtl/byte_to_ascii_number_formatter.sv @@
// An accepted byte's text goes into the character buffer and from there to the output register.
// Output: one character per cycle unless out_ch.ready stalls; a byte's one to four characters
// pass through the single character output register, and an unused format gives no characters.
// The next byte is accepted in the cycle its predecessor's last character moves to the output.
// Reset: synchronous, active low rst_n; the character buffer and the output are emptied.
module byte_to_ascii_number_formatter import bafmt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  bafmt_in_if.sink     in_ch,
  bafmt_out_if.source  out_ch
);

  // The whole text of a byte is formatted as the byte is accepted and lands in a
  // small character buffer. The buffer drains through the output register one
  // character per cycle when not stalled, and registers part the two sides.
  text_t                           text;
  logic [TEXT_MAX-1:0][CHAR_W-1:0] buf_r;
  logic [TEXT_MAX-1:0][CHAR_W-1:0] buf_nxt;
  len_t                            cnt_r;
  len_t                            cnt_nxt;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  char_t                           out_code_r;
  logic                            out_last_r;
  logic                            out_load;
  logic                            in_fire;

  bafmt_encode u_encode (
    .cmd   (in_ch.cmd),
    .value (in_ch.value),
    .text  (text)
  );

  // A character moves on when the output register is empty or being emptied.
  assign out_load = (cnt_r != '0) && (!out_valid_r || out_ch.ready);

  // A new byte is taken when the buffer is empty, or when its last character is
  // moving to the output in this very cycle.
  assign in_ch.ready = (cnt_r == '0) || ((cnt_r == len_t'(1)) && out_load);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (in_fire) begin
      buf_nxt = text.chars;
      cnt_nxt = text.len;
    end else if (out_load) begin
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
      buf_nxt[2] = buf_r[3];
      buf_nxt[3] = '0;
      cnt_nxt    = cnt_r - len_t'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (out_load) begin
      out_code_r <= buf_r[0];
      out_last_r <= (cnt_r == len_t'(1));
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_code_r;
  assign out_ch.last_char = out_last_r;

endmodule

@@ rtl/bafmt_encode.sv @@
module bafmt_encode import bafmt_pkg::*; (
  input  logic [CMD_W-1:0]   cmd,
  input  logic [VALUE_W-1:0] value,
  output text_t              text
);

  logic [VALUE_W-1:0] mag;
  logic [1:0]         hund;
  logic [6:0]         rem;
  logic [14:0]        prod;
  digit_t             tens;
  digit_t             ones;
  digit_t             d2;
  digit_t             d1;
  digit_t             d0;
  logic [1:0]         ndig;
  logic               signed_fmt;
  char_t              sign_ch;
  char_t              dch0;
  char_t              dch1;
  char_t              dch2;

  // Decimal digits of the magnitude. The tens digit of a remainder below one
  // hundred is taken by multiplying with 205/2048, which is exact there.
  always_comb begin
    case (fmt_e'(cmd))
      FMT_TDEC: mag = value[7] ? (8'd128 - {1'b0, value[6:0]}) : value;
      FMT_SDEC: mag = {1'b0, value[6:0]};
      default:  mag = value;
    endcase

    if (mag >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(mag - 8'd200);
    end else if (mag >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(mag - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = mag[6:0];
    end

    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = 4'(rem - 7'(tens) * 7'd10);
  end

  // Digit selection per radix, least significant digit in d0.
  always_comb begin
    signed_fmt = 1'b0;
    sign_ch    = value[7] ? CH_MINUS : CH_PLUS;
    d2         = '0;
    d1         = '0;
    d0         = '0;
    ndig       = 2'd0;
    case (fmt_e'(cmd))
      FMT_OCT: begin
        d2   = {2'b00, value[7:6]};
        d1   = {1'b0, value[5:3]};
        d0   = {1'b0, value[2:0]};
        ndig = (value >= 8'd64) ? 2'd3 : ((value >= 8'd8) ? 2'd2 : 2'd1);
      end
      FMT_HEX: begin
        d1   = value[7:4];
        d0   = value[3:0];
        ndig = (value >= 8'd16) ? 2'd2 : 2'd1;
      end
      FMT_UDEC, FMT_TDEC, FMT_SDEC: begin
        signed_fmt = (fmt_e'(cmd) != FMT_UDEC);
        d2   = {2'b00, hund};
        d1   = tens;
        d0   = ones;
        ndig = (mag >= 8'd100) ? 2'd3 : ((mag >= 8'd10) ? 2'd2 : 2'd1);
      end
      default: begin
        ndig = 2'd0;
      end
    endcase
  end

  // Leading zeros are dropped by aligning the top significant digit first.
  always_comb begin
    case (ndig)
      2'd3: begin
        dch0 = digit_char(d2);
        dch1 = digit_char(d1);
        dch2 = digit_char(d0);
      end
      2'd2: begin
        dch0 = digit_char(d1);
        dch1 = digit_char(d0);
        dch2 = '0;
      end
      default: begin
        dch0 = digit_char(d0);
        dch1 = '0;
        dch2 = '0;
      end
    endcase

    if (signed_fmt) begin
      text.chars[0] = sign_ch;
      text.chars[1] = dch0;
      text.chars[2] = dch1;
      text.chars[3] = dch2;
      text.len      = len_t'(ndig) + len_t'(1);
    end else begin
      text.chars[0] = dch0;
      text.chars[1] = dch1;
      text.chars[2] = dch2;
      text.chars[3] = '0;
      text.len      = len_t'(ndig);
    end
  end

endmodule

@@ rtl/bafmt_checker.sv @@
module bafmt_checker import bafmt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] char_code,
  input logic              last_char
);

  // A character waiting on a stalled output holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char))
    else $error("stalled output character changed");

  // No new byte enters while a character that is not the last one is stuck.
  a_no_early_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_char && !out_ready |-> !in_ready)
    else $error("input accepted while text of the previous byte still pending");

  // A sign never ends a text.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (char_code == CH_PLUS || char_code == CH_MINUS) |-> !last_char)
    else $error("sign character flagged as last");

  // Only digits, A to F and the two signs are ever sent.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((char_code >= 7'h30 && char_code <= 7'h39) ||
                   (char_code >= 7'h41 && char_code <= 7'h46) ||
                   char_code == CH_PLUS || char_code == CH_MINUS))
    else $error("character outside the formatter's set");

  // Reset leaves the output empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind byte_to_ascii_number_formatter bafmt_checker u_bafmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .char_code (out_ch.char_code),
  .last_char (out_ch.last_char)
);

@@ tb/sv/tb_byte_to_ascii_number_formatter.sv @@
module tb_byte_to_ascii_number_formatter;
  import bafmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Selector codes that the block must swallow without producing any text.
  localparam logic [CMD_W-1:0] FMT_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] FMT_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] FMT_RSVD_7 = 3'd7;

  localparam int unsigned RANDOM_WORDS = 445;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;

  // One character that the block still owes us, with its end-of-text flag.
  typedef struct {
    char_t code;
    logic  last;
  } due_char_t;

  // What the driver knows about a word it has put on the bus. Rows of the
  // directed table carry their text typed in; everything else is predicted.
  typedef struct {
    bit    typed;
    string text;
  } word_note_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    string              text;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bafmt_in_if  in_ch ();
  bafmt_out_if out_ch ();

  byte_to_ascii_number_formatter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  due_char_t  chars_due[$];
  word_note_t words_offered[$];
  int unsigned mismatches = 0;
  bit hold_output = 1'b0;

  // The directed part: extremes of each format, both signed encodings of the
  // sign bit, negative zero in sign-magnitude, the two's-complement minimum and
  // the unused selectors. Rows with typed = 0 are checked against the predictor.
  stim_row_t directed_rows[24] = '{
    '{FMT_OCT,    8'h00, 1'b1, "0"},
    '{FMT_OCT,    8'hFF, 1'b1, "377"},
    '{FMT_UDEC,   8'h00, 1'b1, "0"},
    '{FMT_UDEC,   8'hFF, 1'b1, "255"},
    '{FMT_HEX,    8'h00, 1'b1, "0"},
    '{FMT_HEX,    8'hFF, 1'b1, "FF"},
    '{FMT_TDEC,   8'h00, 1'b1, "+0"},
    '{FMT_TDEC,   8'h7F, 1'b1, "+127"},
    '{FMT_TDEC,   8'h80, 1'b1, "-128"},
    '{FMT_TDEC,   8'hFF, 1'b1, "-1"},
    '{FMT_SDEC,   8'h00, 1'b1, "+0"},
    '{FMT_SDEC,   8'h7F, 1'b1, "+127"},
    '{FMT_SDEC,   8'h80, 1'b1, "-0"},
    '{FMT_SDEC,   8'hFF, 1'b1, "-127"},
    '{FMT_RSVD_5, 8'hAA, 1'b1, ""},
    '{FMT_RSVD_6, 8'h55, 1'b1, ""},
    '{FMT_RSVD_7, 8'hFF, 1'b1, ""},
    '{FMT_OCT,    8'h08, 1'b0, ""},
    '{FMT_UDEC,   8'h64, 1'b0, ""},
    '{FMT_UDEC,   8'h09, 1'b0, ""},
    '{FMT_HEX,    8'hA5, 1'b0, ""},
    '{FMT_HEX,    8'h0F, 1'b0, ""},
    '{FMT_TDEC,   8'h9C, 1'b0, ""},
    '{FMT_SDEC,   8'h8A, 1'b0, ""}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the text that the block should give for one byte. An unused
  // selector gives the empty string, that is, no characters at all.
  function automatic string format_text(input logic [CMD_W-1:0] cmd,
                                        input logic [VALUE_W-1:0] value);
    string digit_set;
    string digits;
    string sign;
    int unsigned radix;
    int unsigned mag;
    digit_set = "0123456789ABCDEF";
    digits = "";
    sign = "";
    case (cmd)
      FMT_OCT: begin
        radix = 8;
        mag = value;
      end
      FMT_UDEC: begin
        radix = 10;
        mag = value;
      end
      FMT_HEX: begin
        radix = 16;
        mag = value;
      end
      FMT_TDEC: begin
        radix = 10;
        sign = $sformatf("%c", value[7] ? CH_MINUS : CH_PLUS);
        // A negative byte stands for minus (128 less its low seven bits).
        mag = value[7] ? 128 - value[6:0] : value;
      end
      FMT_SDEC: begin
        radix = 10;
        sign = $sformatf("%c", value[7] ? CH_MINUS : CH_PLUS);
        mag = value[6:0];
      end
      default: begin
        return "";
      end
    endcase
    // Leading zeros never appear, yet a zero magnitude still leaves one digit.
    do begin
      digits = $sformatf("%c%s", digit_set[mag % radix], digits);
      mag = mag / radix;
    end while (mag != 0);
    return {sign, digits};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Puts one word on the input bus and holds it until the block takes it.
  // With no gap afterwards valid stays high, so the caller must offer the next
  // word at once or lower valid itself in the same step.
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                       input bit typed, input string text, input bit back_to_back);
    int unsigned r;
    int unsigned gap;
    words_offered.push_back('{typed, text});
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    r = $urandom_range(0, 99);
    if (back_to_back || r < 45) begin
      gap = 0;
    end else if (r < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every word has been taken and all its
  // characters have come out, then lets the block finish any unused selector.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (chars_due.size() != 0 || words_offered.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: ready is driven in runs of random length, mostly short, with
  // the odd long stall and long stretches of steady readiness. When asked, it
  // holds off for a long count of cycles so that the block backs up.
  initial begin
    bit level;
    int unsigned run;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_output) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        level = ($urandom_range(0, 99) < 70);
        if (level) begin
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        end else begin
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
        end
        out_ch.ready <= level;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Scoreboard. Both buses are sampled at the rising edge, before any of this
  // edge's updates land. Characters leaving the block are checked first; a word
  // taken at the same edge cannot yet have produced any of them.
  always @(posedge clk) begin
    due_char_t  want;
    word_note_t note;
    string      text;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("character 0x%0h with nothing expected", out_ch.char_code));
        end else begin
          want = chars_due.pop_front();
          if (out_ch.char_code !== want.code) begin
            report_mismatch($sformatf("char_code 0x%0h, expected 0x%0h",
                                      out_ch.char_code, want.code));
          end
          if (out_ch.last_char !== want.last) begin
            report_mismatch($sformatf("last_char %b, expected %b on char 0x%0h",
                                      out_ch.last_char, want.last, want.code));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (words_offered.size() == 0) begin
          report_mismatch("word taken that was never offered");
        end else begin
          note = words_offered.pop_front();
          text = note.typed ? note.text : format_text(in_ch.cmd, in_ch.value);
          for (int i = 0; i < text.len(); i++) begin
            chars_due.push_back('{char_t'(text[i]), logic'(i == text.len() - 1)});
          end
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random words. Part of the way
  // in, the result side is told to hold off while words keep coming, later
  // there is a run of back-to-back words, and later still the driver pauses
  // until the block has emptied.
  initial begin
    int unsigned sent;
    int unsigned r;
    bit hold_done;
    bit drain_done;
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] edge_values[6];
    edge_values = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFF};
    sent = 0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= FMT_OCT;
    in_ch.value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
            directed_rows[i].text, 1'b0);
    end
    drain();

    while (sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        cmd = CMD_W'($urandom_range(FMT_RSVD_5, FMT_RSVD_7));
      end else begin
        cmd = CMD_W'($urandom_range(FMT_OCT, FMT_SDEC));
      end
      if ($urandom_range(0, 99) < 15) begin
        value = edge_values[$urandom_range(0, 5)];
      end else begin
        value = VALUE_W'($urandom_range(0, 255));
      end
      if (sent == 150 && !hold_done) begin
        hold_output = 1'b1;
        hold_done = 1'b1;
      end
      if (sent == 320 && !drain_done) begin
        drain();
        drain_done = 1'b1;
      end
      offer(cmd, value, 1'b0, "", sent >= 220 && sent < 270);
      sent++;
    end

    in_ch.valid <= 1'b0;
    while (chars_due.size() != 0 || words_offered.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t ns: timeout, %0d characters still due", $time, chars_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
